/* hw/rtl/sppa_pkg.sv */
// Shared types, constants and coefficient functions of the piecewise-polynomial sine block.
// Depends on nothing; every other file of the block depends on it.
`default_nettype none

package sppa_pkg;

	// Field widths.
	localparam int ANGLE_W = 48;
	localparam int SINE_W  = 32;
	localparam int DATA_W  = 32;
	localparam int PROD_W  = 2 * DATA_W;

	// Range reduction works on a biased unsigned copy of the angle.
	localparam int REM_W      = ANGLE_W + 1;
	localparam int DIV_STEPS  = 15;
	localparam int TWO_PI_W   = 35;
	localparam int PI_W       = 34;
	localparam int HALF_PI_W  = 33;

	// Angles in units of 2^-32 radian.
	localparam logic [TWO_PI_W-1:0]  TWO_PI     = 35'd26986075409;
	localparam logic [PI_W-1:0]      PI         = 34'd13493037705;
	localparam logic [HALF_PI_W-1:0] HALF_PI    = 33'd6746518852;
	localparam logic [HALF_PI_W-1:0] QUARTER_PI = 33'd3373259426;

	// 5216 turns: a whole multiple of two pi that lifts every angle above zero.
	localparam logic [REM_W-1:0] REM_OFFSET = 49'd140759369333344;

	// Rounding bias of the argument conversion from Q32 to Q30.
	localparam logic [HALF_PI_W:0] ARG_BIAS = 34'd2;

	// Q30 values.
	localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sd1073741824;
	localparam logic [PROD_W-1:0] ROUND_HALF = 64'd536870912;

	localparam logic signed [DATA_W-1:0] COEF_S1 = 32'sd178957040;
	localparam logic signed [DATA_W-1:0] COEF_S3 = 32'sd8947553;
	localparam logic signed [DATA_W-1:0] COEF_S5 = 32'sd210651;
	localparam logic signed [DATA_W-1:0] COEF_S7 = 32'sd246;
	localparam logic signed [DATA_W-1:0] COEF_C2 = 32'sd536870688;
	localparam logic signed [DATA_W-1:0] COEF_C4 = 32'sd44738996;
	localparam logic signed [DATA_W-1:0] COEF_C6 = 32'sd1492424;
	localparam logic signed [DATA_W-1:0] COEF_C8 = 32'sd28258;

	// Multiply-add steps of the evaluator: square, four Horner steps, final product.
	localparam int STEP_SQUARE = 0;
	localparam int STEP_FINAL  = 5;
	localparam int NUM_STEPS   = 6;

	// What travels down the evaluator with each angle.
	typedef struct packed {
		logic                     neg;
		logic                     cos_br;
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] s;
		logic signed [DATA_W-1:0] acc;
	} tok_t;

	// Starting value of the Horner accumulator.
	function automatic logic signed [DATA_W-1:0] acc_init(input logic cos_br);
		return cos_br ? COEF_C8 : -COEF_S7;
	endfunction

	// Constant added after the product of a given step.
	function automatic logic signed [DATA_W-1:0] step_addend(input int step, input logic cos_br);
		logic signed [DATA_W-1:0] k;
		case (step)
			1:       k = cos_br ? -COEF_C6 : -COEF_S5;
			2:       k = cos_br ? COEF_C4 : COEF_S3;
			3:       k = cos_br ? -COEF_C2 : -COEF_S1;
			4:       k = ONE_Q30;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] a);
		return a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/sppa_angle_if.sv */
// Handshake channel that carries one angle per transfer.
// Depends on sppa_pkg for the field width.
`default_nettype none

interface sppa_angle_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [sppa_pkg::ANGLE_W-1:0]   angle;

	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sppa_sine_if.sv */
// Handshake channel that carries one sine value per transfer.
// Depends on sppa_pkg for the field width.
`default_nettype none

interface sppa_sine_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sppa_pkg::SINE_W-1:0]   sine;

	modport source (output valid, output sine, input ready);
	modport sink (input valid, input sine, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sine_piecewise_polynomial.sv */
// Top level of the piecewise-polynomial sine: range reduction, six multiply-add steps,
// saturation and the output register. Depends on sppa_pkg, sppa_angle_if, sppa_sine_if,
// sppa_reduce and sppa_step.
//
// Usage:
// The block takes one angle per transfer on angle_stream (signed, 32 fractional bits)
// and returns its sine on sine_stream (signed, 30 fractional bits, within plus or
// minus one). Every angle gives exactly one sine, in the order the angles came in.
// From the input transfer to the result, an angle passes one bias stage, fifteen
// restoring steps of the modulo-two-pi reduction, three folding stages, six
// multiply-add steps of two stages each, and the saturating output register.
// Throughput is one angle per cycle while the receiver takes results; the rate is set
// by the pipeline, which holds one angle in every stage.
// Every stage has its own valid bit and advances when it is empty or when the
// stage after it advances, so a stalled receiver fills the pipeline bubble by
// bubble and nothing is lost or repeated. While the result waits, the input still
// takes angles until every stage holds one.
// Reset clears all valid bits; the data registers are not reset and there is no configuration.
`default_nettype none

module sine_piecewise_polynomial (
	input  logic               clk,
	input  logic               arst_n,
	sppa_angle_if.sink         angle_stream,
	sppa_sine_if.source        sine_stream
);
	import sppa_pkg::*;

	// Element j feeds step j; the last element feeds the output stage.
	tok_t                 chain_tok [NUM_STEPS+1];
	logic [NUM_STEPS:0]   chain_vld;
	logic [NUM_STEPS:0]   chain_rdy;

	logic                     sine_vld_q;
	logic signed [SINE_W-1:0] sine_q;
	logic                     out_adv;
	logic signed [DATA_W-1:0] y_sat;

	sppa_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (angle_stream.valid),
		.up_ready (angle_stream.ready),
		.up_angle (angle_stream.angle),
		.dn_valid (chain_vld[0]),
		.dn_ready (chain_rdy[0]),
		.dn_tok   (chain_tok[0])
	);

	// Square of the argument, the four Horner steps, then the product with the argument
	// (sine branch) or with one (cosine branch).
	for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
		sppa_step #(
			.STEP (j)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_vld[j]),
			.up_ready (chain_rdy[j]),
			.up_tok   (chain_tok[j]),
			.dn_valid (chain_vld[j+1]),
			.dn_ready (chain_rdy[j+1]),
			.dn_tok   (chain_tok[j+1])
		);
	end

	assign out_adv              = !sine_vld_q || sine_stream.ready;
	assign chain_rdy[NUM_STEPS] = out_adv;

	// The polynomial is clamped to plus or minus one before the sign of the angle is applied,
	// so odd symmetry holds exactly.
	always_comb begin
		if (chain_tok[NUM_STEPS].acc > ONE_Q30) begin
			y_sat = ONE_Q30;
		end else if (chain_tok[NUM_STEPS].acc < -ONE_Q30) begin
			y_sat = -ONE_Q30;
		end else begin
			y_sat = chain_tok[NUM_STEPS].acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sine_vld_q <= 1'b0;
		end else if (out_adv) begin
			sine_vld_q <= chain_vld[NUM_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && chain_vld[NUM_STEPS]) begin
			sine_q <= chain_tok[NUM_STEPS].neg ? SINE_W'(-y_sat) : SINE_W'(y_sat);
		end
	end

	assign sine_stream.valid = sine_vld_q;
	assign sine_stream.sine  = sine_q;

endmodule

`default_nettype wire

/* hw/rtl/sppa_reduce.sv */
// Range reduction: angle modulo two pi, folding into [0, pi/2], branch choice and Q30 argument.
// Depends on sppa_pkg.
`default_nettype none

module sppa_reduce (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                up_valid,
	output logic                                up_ready,
	input  logic signed [sppa_pkg::ANGLE_W-1:0] up_angle,
	output logic                                dn_valid,
	input  logic                                dn_ready,
	output sppa_pkg::tok_t                      dn_tok
);
	import sppa_pkg::*;

	// Element 0 holds the biased angle, element k the remainder after k restoring steps.
	logic [REM_W-1:0]     rem_s [DIV_STEPS+1];
	logic [DIV_STEPS:0]   vld_s;
	logic [DIV_STEPS:0]   adv;

	logic                 vld_s17, neg_s17;
	logic [PI_W-1:0]      mag_s17;
	logic                 vld_s18, neg_s18;
	logic [HALF_PI_W-1:0] fold_s18;
	logic                 vld_s19;
	tok_t                 tok_s19;
	logic                 adv17, adv18, adv19;

	logic [TWO_PI_W-1:0]  rem_fin;
	logic                 cos_sel;
	logic [HALF_PI_W-1:0] arg_mag;
	logic [HALF_PI_W:0]   arg_sum;

	assign adv19 = !vld_s19 || dn_ready;
	assign adv18 = !vld_s18 || adv19;
	assign adv17 = !vld_s17 || adv18;

	always_comb begin
		adv[DIV_STEPS] = !vld_s[DIV_STEPS] || adv17;
		for (int k = DIV_STEPS - 1; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign up_ready = adv[0];

	// Bias stage first, then one quotient bit per stage, largest multiple of two pi first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= up_valid;
			end
			for (int k = 1; k <= DIV_STEPS; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Adding a whole number of turns keeps the remainder unchanged.
	always_ff @(posedge clk) begin
		if (adv[0] && up_valid) begin
			rem_s[0] <= REM_W'(up_angle) + REM_OFFSET;
		end
		for (int k = 1; k <= DIV_STEPS; k++) begin
			if (adv[k] && vld_s[k-1]) begin
				rem_s[k] <= (rem_s[k-1] >= (REM_W'(TWO_PI) << (DIV_STEPS - k)))
					? rem_s[k-1] - (REM_W'(TWO_PI) << (DIV_STEPS - k)) : rem_s[k-1];
			end
		end
	end

	assign rem_fin = rem_s[DIV_STEPS][TWO_PI_W-1:0];

	always_comb begin
		cos_sel = fold_s18 >= QUARTER_PI;
		arg_mag = cos_sel ? HALF_PI - fold_s18 : fold_s18;
		arg_sum = {1'b0, arg_mag} + ARG_BIAS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s17 <= 1'b0;
			vld_s18 <= 1'b0;
			vld_s19 <= 1'b0;
		end else begin
			if (adv17) begin
				vld_s17 <= vld_s[DIV_STEPS];
			end
			if (adv18) begin
				vld_s18 <= vld_s17;
			end
			if (adv19) begin
				vld_s19 <= vld_s18;
			end
		end
	end

	always_ff @(posedge clk) begin
		// A remainder above pi maps to the negative side; keep its magnitude.
		if (adv17 && vld_s[DIV_STEPS]) begin
			neg_s17 <= rem_fin > TWO_PI_W'(PI);
			mag_s17 <= (rem_fin > TWO_PI_W'(PI)) ? PI_W'(TWO_PI - rem_fin) : PI_W'(rem_fin);
		end
		// Reflect about pi/2; exactly pi/2 stays as it is.
		if (adv18 && vld_s17) begin
			neg_s18  <= neg_s17;
			fold_s18 <= (mag_s17 > PI_W'(HALF_PI)) ? HALF_PI_W'(PI - mag_s17)
			                                      : HALF_PI_W'(mag_s17);
		end
		if (adv19 && vld_s18) begin
			tok_s19.neg    <= neg_s18;
			tok_s19.cos_br <= cos_sel;
			tok_s19.v      <= signed'(arg_sum[HALF_PI_W:2]);
			tok_s19.s      <= '0;
			tok_s19.acc    <= '0;
		end
	end

	assign dn_valid = vld_s19;
	assign dn_tok   = tok_s19;

endmodule

`default_nettype wire

/* hw/rtl/sppa_step.sv */
// One multiply-add step of the evaluator: a registered magnitude product, then Q30
// rounding half away from zero and the step's constant. Depends on sppa_pkg.
`default_nettype none

module sppa_step #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  sppa_pkg::tok_t up_tok,
	output logic           dn_valid,
	input  logic           dn_ready,
	output sppa_pkg::tok_t dn_tok
);
	import sppa_pkg::*;

	logic signed [DATA_W-1:0] op_a, op_b;
	logic                     vld_s1, sgn_s1, vld_s2;
	logic [PROD_W-1:0]        prod_s1;
	tok_t                     tok_s1, tok_s2;
	logic                     adv1, adv2;

	logic [PROD_W-1:0]        rnd;
	logic signed [DATA_W+2:0] term;
	logic signed [DATA_W+2:0] sum;
	logic signed [DATA_W-1:0] res;
	tok_t                     tok_next;

	always_comb begin
		if (STEP == STEP_SQUARE) begin
			op_a = up_tok.v;
			op_b = up_tok.v;
		end else if (STEP == STEP_FINAL) begin
			// The cosine branch ends with the accumulator itself; times one is exact.
			op_a = up_tok.cos_br ? ONE_Q30 : up_tok.v;
			op_b = up_tok.acc;
		end else begin
			op_a = up_tok.s;
			op_b = up_tok.acc;
		end
	end

	assign adv2     = !vld_s2 || dn_ready;
	assign adv1     = !vld_s1 || adv2;
	assign up_ready = adv1;

	always_comb begin
		rnd  = prod_s1 + ROUND_HALF;
		term = sgn_s1 ? -signed'({1'b0, rnd[PROD_W-1:30]}) : signed'({1'b0, rnd[PROD_W-1:30]});
		sum  = (DATA_W+3)'(step_addend(STEP, tok_s1.cos_br)) + term;
		res  = DATA_W'(sum);
		tok_next = tok_s1;
		if (STEP == STEP_SQUARE) begin
			tok_next.s   = res;
			tok_next.acc = acc_init(tok_s1.cos_br);
		end else begin
			tok_next.acc = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				vld_s1 <= up_valid;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && up_valid) begin
			prod_s1 <= mag(op_a) * mag(op_b);
			sgn_s1  <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
			tok_s1  <= up_tok;
		end
		if (adv2 && vld_s1) begin
			tok_s2 <= tok_next;
		end
	end

	assign dn_valid = vld_s2;
	assign dn_tok   = tok_s2;

endmodule

`default_nettype wire
